// ----- sv/glcw_pkg.sv -----
// shared constants and helpers for the grid line cell walker
`default_nettype none
package glcw_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int CELL_W          = 24;
    localparam int LIM_W           = 6;
    localparam int NUM_W           = 31;
    localparam int CELL_OUT_W      = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CELLS = 2'd1;

    localparam logic [CELL_W-1:0] CELL_LEN_RST  = 24'd256;
    localparam logic [LIM_W-1:0]  MAX_CELLS_RST = 6'd62;
    localparam logic [LIM_W-1:0]  MAX_CELLS_TOP = 6'd62;

    localparam int OUT_DATA_W = 2 * CELL_OUT_W + 1;

    function automatic int desc_w(input int w);
        return 6 * w + CELL_W + LIM_W + 4 + 2 * NUM_W + 4 * (NUM_W + w);
    endfunction
endpackage
`default_nettype wire

// ----- sv/glcw_fifo.sv -----
// small register queue used between the walker stages and at the result side
`default_nettype none
module glcw_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_rd,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              wr_en, rd_en;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/glcw_front.sv -----
// segment setup: cell indices by serial division, crossing products by shift-add
`default_nettype none
module glcw_front #(
    parameter int COORD_WIDTH = glcw_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic [COORD_WIDTH-1:0]            i_start_x,
    input  wire logic [COORD_WIDTH-1:0]            i_start_y,
    input  wire logic [COORD_WIDTH-1:0]            i_end_x,
    input  wire logic [COORD_WIDTH-1:0]            i_end_y,
    input  wire logic [glcw_pkg::CELL_W-1:0]       i_cell_len,
    input  wire logic [glcw_pkg::LIM_W-1:0]        i_max_cells,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [glcw_pkg::desc_w(COORD_WIDTH)-1:0] o_desc
);
    localparam int W     = COORD_WIDTH;
    localparam int CW    = glcw_pkg::CELL_W;
    localparam int LW    = glcw_pkg::LIM_W;
    localparam int NW    = glcw_pkg::NUM_W;
    localparam int PW    = NW + W;
    localparam int CNT_W = $clog2(W + 1);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIV  = 3'd1;
    localparam logic [2:0] F_FIX  = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]       r_fst;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_crd [4];
    logic [W-1:0]     r_quo [4];
    logic [CW-1:0]    r_rem [4];
    logic [CW-1:0]    r_c;
    logic [LW-1:0]    r_lim;
    logic [W-1:0]     r_cell [4];
    logic [W-1:0]     r_adx, r_ady;
    logic             r_zx, r_zy, r_negx, r_negy;
    logic [NW-1:0]    r_nx, r_ny;
    logic [CW-1:0]    r_ma, r_mb, r_mc;
    logic [PW-1:0]    r_p, r_q, r_kx, r_ky;

    logic [W-1:0]     n_quo [4];
    logic [CW-1:0]    n_rem [4];
    logic [W-1:0]     fix_q [4];
    logic [CW-1:0]    fix_r [4];
    logic [CW:0]      sh;
    logic             ge, neg, rz;
    logic [W:0]       dxw, dyw, ndx, ndy;
    logic             negx, negy, zx, zy;
    logic [CW-1:0]    nx0, ny0;
    logic             accept;

    assign o_full  = r_fst != F_IDLE;
    assign o_valid = r_fst == F_PUSH;
    assign accept  = i_push && r_fst == F_IDLE;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sh       = {r_rem[i], r_quo[i][W-1]};
            ge       = sh >= {1'b0, r_c};
            n_rem[i] = ge ? CW'(sh - {1'b0, r_c}) : sh[CW-1:0];
            n_quo[i] = {r_quo[i][W-2:0], ge};
            neg      = r_crd[i][W-1];
            rz       = r_rem[i] == '0;
            fix_q[i] = neg ? (rz ? ~r_quo[i] + 1'b1 : ~r_quo[i]) : r_quo[i];
            fix_r[i] = (neg && !rz) ? r_c - r_rem[i] : r_rem[i];
        end
    end

    always_comb begin
        dxw  = {r_crd[2][W-1], r_crd[2]} - {r_crd[0][W-1], r_crd[0]};
        dyw  = {r_crd[3][W-1], r_crd[3]} - {r_crd[1][W-1], r_crd[1]};
        ndx  = '0 - dxw;
        ndy  = '0 - dyw;
        negx = dxw[W];
        negy = dyw[W];
        zx   = dxw == '0;
        zy   = dyw == '0;
        nx0  = (!negx && !zx) ? r_c - fix_r[0] : fix_r[0];
        ny0  = (!negy && !zy) ? r_c - fix_r[1] : fix_r[1];
    end

    assign o_desc = {r_cell[0], r_cell[1], r_cell[2], r_cell[3], r_adx, r_ady, r_c, r_lim,
                     r_zx, r_zy, r_negx, r_negy, r_nx, r_ny, r_p, r_q, r_kx, r_ky};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst <= F_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_fst)
                F_IDLE: begin
                    if (accept) begin
                        r_fst <= F_DIV;
                        r_cnt <= '0;
                    end
                end
                F_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_fst <= F_FIX;
                    end
                end
                F_FIX: begin
                    r_fst <= F_MUL;
                    r_cnt <= '0;
                end
                F_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CW - 1)) begin
                        r_fst <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_ready) begin
                        r_fst <= F_IDLE;
                    end
                end
                default: r_fst <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_fst)
            F_IDLE: begin
                if (accept) begin
                    r_crd[0] <= i_start_x;
                    r_crd[1] <= i_start_y;
                    r_crd[2] <= i_end_x;
                    r_crd[3] <= i_end_y;
                    r_quo[0] <= i_start_x[W-1] ? '0 - i_start_x : i_start_x;
                    r_quo[1] <= i_start_y[W-1] ? '0 - i_start_y : i_start_y;
                    r_quo[2] <= i_end_x[W-1] ? '0 - i_end_x : i_end_x;
                    r_quo[3] <= i_end_y[W-1] ? '0 - i_end_y : i_end_y;
                    for (int i = 0; i < 4; i++) begin
                        r_rem[i] <= '0;
                    end
                    r_c   <= (i_cell_len == '0) ? CW'(1) : i_cell_len;
                    r_lim <= (i_max_cells == '0) ? LW'(1) :
                             (i_max_cells > glcw_pkg::MAX_CELLS_TOP) ?
                             glcw_pkg::MAX_CELLS_TOP : i_max_cells;
                end
            end
            F_DIV: begin
                for (int i = 0; i < 4; i++) begin
                    r_quo[i] <= n_quo[i];
                    r_rem[i] <= n_rem[i];
                end
            end
            F_FIX: begin
                for (int i = 0; i < 4; i++) begin
                    r_cell[i] <= fix_q[i];
                end
                r_adx  <= negx ? ndx[W-1:0] : dxw[W-1:0];
                r_ady  <= negy ? ndy[W-1:0] : dyw[W-1:0];
                r_zx   <= zx;
                r_zy   <= zy;
                r_negx <= negx;
                r_negy <= negy;
                r_nx   <= NW'(nx0);
                r_ny   <= NW'(ny0);
                r_ma   <= nx0;
                r_mb   <= ny0;
                r_mc   <= r_c;
                r_p    <= '0;
                r_q    <= '0;
                r_kx   <= '0;
                r_ky   <= '0;
            end
            F_MUL: begin
                r_p  <= {r_p[PW-2:0], 1'b0} + (r_ma[CW-1] ? PW'(r_ady) : '0);
                r_q  <= {r_q[PW-2:0], 1'b0} + (r_mb[CW-1] ? PW'(r_adx) : '0);
                r_kx <= {r_kx[PW-2:0], 1'b0} + (r_mc[CW-1] ? PW'(r_ady) : '0);
                r_ky <= {r_ky[PW-2:0], 1'b0} + (r_mc[CW-1] ? PW'(r_adx) : '0);
                r_ma <= {r_ma[CW-2:0], 1'b0};
                r_mb <= {r_mb[CW-2:0], 1'b0};
                r_mc <= {r_mc[CW-2:0], 1'b0};
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/glcw_back.sv -----
// cell stepping: one visited cell per cycle into the result queue while it is not full
`default_nettype none
module glcw_back #(
    parameter int COORD_WIDTH = glcw_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [glcw_pkg::desc_w(COORD_WIDTH)-1:0] i_desc,
    input  wire logic                                  i_out_full,
    output logic                                       o_out_wr,
    output logic [glcw_pkg::OUT_DATA_W-1:0]            o_out_data
);
    localparam int W  = COORD_WIDTH;
    localparam int CW = glcw_pkg::CELL_W;
    localparam int LW = glcw_pkg::LIM_W;
    localparam int NW = glcw_pkg::NUM_W;
    localparam int PW = NW + W;
    localparam int OW = glcw_pkg::CELL_OUT_W;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_WALK = 2'd1;
    localparam logic [1:0] B_ENDC = 2'd2;

    logic [1:0]    r_bst;
    logic [W-1:0]  r_col, r_row, r_ecol, r_erow, r_adx, r_ady;
    logic [CW-1:0] r_c;
    logic [LW-1:0] r_lim, r_it;
    logic          r_zx, r_zy, r_negx, r_negy;
    logic [NW-1:0] r_nx, r_ny;
    logic [PW-1:0] r_p, r_q, r_kx, r_ky;

    logic [W-1:0]  d_col, d_row, d_ecol, d_erow, d_adx, d_ady;
    logic [CW-1:0] d_c;
    logic [LW-1:0] d_lim;
    logic          d_zx, d_zy, d_negx, d_negy;
    logic [NW-1:0] d_nx, d_ny;
    logic [PW-1:0] d_p, d_q, d_kx, d_ky;

    logic          same, stepx, stepy, xpast, ypast, atend, fin, endnext;
    logic [W-1:0]  n_col, n_row, e_col, e_row;
    logic [NW-1:0] n_nx, n_ny;
    logic [LW-1:0] n_it;
    logic          e_last;

    assign {d_col, d_row, d_ecol, d_erow, d_adx, d_ady, d_c, d_lim,
            d_zx, d_zy, d_negx, d_negy, d_nx, d_ny, d_p, d_q, d_kx, d_ky} = i_desc;

    assign same    = d_col == d_ecol && d_row == d_erow;
    assign o_ready = r_bst == B_IDLE && !i_out_full;

    always_comb begin
        stepx   = r_zy || (!r_zx && r_p <= r_q);
        stepy   = r_zx || (!r_zy && r_p >= r_q);
        n_col   = stepx ? (r_negx ? r_col - 1'b1 : r_col + 1'b1) : r_col;
        n_row   = stepy ? (r_negy ? r_row - 1'b1 : r_row + 1'b1) : r_row;
        n_nx    = stepx ? r_nx + NW'(r_c) : r_nx;
        n_ny    = stepy ? r_ny + NW'(r_c) : r_ny;
        n_it    = r_it + 1'b1;
        xpast   = r_zx || (PW'(n_nx) > PW'(r_adx));
        ypast   = r_zy || (PW'(n_ny) > PW'(r_ady));
        atend   = n_col == r_ecol && n_row == r_erow;
        fin     = atend || (!(xpast && ypast) && n_it == r_lim);
        endnext = xpast && ypast && !atend;
    end

    always_comb begin
        o_out_wr = 1'b0;
        e_col    = r_ecol;
        e_row    = r_erow;
        e_last   = 1'b1;
        case (r_bst)
            B_IDLE: begin
                o_out_wr = i_valid && !i_out_full;
                e_col    = d_col;
                e_row    = d_row;
                e_last   = same;
            end
            B_WALK: begin
                o_out_wr = !i_out_full;
                e_col    = n_col;
                e_row    = n_row;
                e_last   = fin;
            end
            B_ENDC: begin
                o_out_wr = !i_out_full;
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = {OW'(signed'(e_col)), OW'(signed'(e_row)), e_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst <= B_IDLE;
        end else begin
            case (r_bst)
                B_IDLE: begin
                    if (i_valid && !i_out_full && !same) begin
                        r_bst <= B_WALK;
                    end
                end
                B_WALK: begin
                    if (!i_out_full) begin
                        if (fin) begin
                            r_bst <= B_IDLE;
                        end else if (endnext) begin
                            r_bst <= B_ENDC;
                        end
                    end
                end
                B_ENDC: begin
                    if (!i_out_full) begin
                        r_bst <= B_IDLE;
                    end
                end
                default: r_bst <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bst == B_IDLE && i_valid && !i_out_full) begin
            r_col  <= d_col;
            r_row  <= d_row;
            r_ecol <= d_ecol;
            r_erow <= d_erow;
            r_adx  <= d_adx;
            r_ady  <= d_ady;
            r_c    <= d_c;
            r_lim  <= d_lim;
            r_zx   <= d_zx;
            r_zy   <= d_zy;
            r_negx <= d_negx;
            r_negy <= d_negy;
            r_nx   <= d_nx;
            r_ny   <= d_ny;
            r_p    <= d_p;
            r_q    <= d_q;
            r_kx   <= d_kx;
            r_ky   <= d_ky;
            r_it   <= '0;
        end else if (r_bst == B_WALK && !i_out_full) begin
            r_col <= n_col;
            r_row <= n_row;
            r_nx  <= n_nx;
            r_ny  <= n_ny;
            r_p   <= stepx ? r_p + r_kx : r_p;
            r_q   <= stepy ? r_q + r_ky : r_q;
            r_it  <= n_it;
        end
    end

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_wr && o_out_data[0]) |=> r_bst == B_IDLE)
        else $error("walk continued after the final beat");

    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bst == B_WALK |-> r_it < r_lim)
        else $error("step count beyond limit");

    a_walk_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bst == B_WALK |-> !(r_zx && r_zy))
        else $error("walk on a zero length segment");

    a_endc_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bst == B_ENDC && !i_out_full) |=> r_bst == B_IDLE)
        else $error("end cell beat not final");
endmodule
`default_nettype wire

// ----- sv/grid_line_cell_walker.sv -----
// top level of the grid line cell walker
// Each segment goes first through a setup stage: a four-lane restoring divider finds the start
// and end cells one quotient bit a cycle, a fix step then fixes signs and remainders, and a
// shift-add unit forms the crossing-time products. full stays high from acceptance through
// division, fix and multiplication, and longer while the segment queue is full, so a new
// segment is taken only once the last one has gone into the queue. A two-entry queue hands the
// segment to the stepping stage, which writes one cell a cycle while the result side keeps up
// (the start cell, up to max_cells steps and possibly the end cell, at most 64) into a
// two-entry result queue. The two stages overlap, so a segment costs the larger of the setup
// interval and its cell count; crossing times are compared exactly, with no rounding.
`default_nettype none
module grid_line_cell_walker #(
    parameter int COORD_WIDTH = glcw_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [COORD_WIDTH-1:0]              i_start_x,
    input  wire logic [COORD_WIDTH-1:0]              i_start_y,
    input  wire logic [COORD_WIDTH-1:0]              i_end_x,
    input  wire logic [COORD_WIDTH-1:0]              i_end_y,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [glcw_pkg::CELL_OUT_W-1:0]          o_cell_x,
    output logic [glcw_pkg::CELL_OUT_W-1:0]          o_cell_y,
    output logic                                     o_last_cell,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [glcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [glcw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int DW = glcw_pkg::desc_w(COORD_WIDTH);
    localparam int OD = glcw_pkg::OUT_DATA_W;

    logic [glcw_pkg::CELL_W-1:0] r_cell_len;
    logic [glcw_pkg::LIM_W-1:0]  r_max_cells;

    logic          f_valid, f_ready, q_full, q_valid, b_ready, o_full_q, o_wr, o_valid;
    logic [DW-1:0] f_desc, q_desc;
    logic [OD-1:0] b_data, r_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_len  <= glcw_pkg::CELL_LEN_RST;
            r_max_cells <= glcw_pkg::MAX_CELLS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                glcw_pkg::REG_CELL_LEN:  r_cell_len  <= i_cfg_data[glcw_pkg::CELL_W-1:0];
                glcw_pkg::REG_MAX_CELLS: r_max_cells <= i_cfg_data[glcw_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    glcw_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_cell_len  (r_cell_len),
        .i_max_cells (r_max_cells),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_desc      (f_desc)
    );

    assign f_ready = !q_full;

    glcw_fifo #(.DATA_W(DW), .DEPTH(2)) u_seg_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_data  (f_desc),
        .o_full  (q_full),
        .i_rd    (b_ready),
        .o_valid (q_valid),
        .o_data  (q_desc)
    );

    glcw_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_ready    (b_ready),
        .i_desc     (q_desc),
        .i_out_full (o_full_q),
        .o_out_wr   (o_wr),
        .o_out_data (b_data)
    );

    glcw_fifo #(.DATA_W(OD), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (o_wr),
        .i_data  (b_data),
        .o_full  (o_full_q),
        .i_rd    (pop),
        .o_valid (o_valid),
        .o_data  (r_data)
    );

    assign empty = !o_valid;
    assign {o_cell_x, o_cell_y, o_last_cell} = r_data;
endmodule
`default_nettype wire
